[sv/crrd_pkg.sv]
// Shared types and widths for the claim resolve ring dilation block.
package crrd_pkg;

  localparam int CFG_W   = 11;
  localparam int COORD_W = 10;

  // Configuration register indexes, one word apart on the APB-style port
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic fill_inclusive;
    logic fill_strict;
    logic foreign_inclusive;
  } claim_t;

  typedef struct packed {
    logic [COORD_W-1:0] texel_x;
    logic [COORD_W-1:0] texel_y;
    logic               painted;
    logic               from_ring;
    logic               frame_last;
  } result_t;

  // Per-texel control carried from the accept stage into the resolve stage
  typedef struct packed {
    logic [COORD_W-1:0] texel_x;
    logic [COORD_W-1:0] texel_y;
    logic               emit;
    logic               up_ok;
    logic               left_ok;
    logic               right_ok;
    logic               down;
    logic               frame_last;
  } tag_t;

  // Write-back from the resolve stage into the older-row fill store
  typedef struct packed {
    logic en;
    logic data;
  } fill_wb_t;

endpackage

[sv/crrd_cfg.sv]
// Configuration registers with the APB-style port and dimension clamping.
module crrd_cfg import crrd_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int WW         = $clog2(MAX_WIDTH + 1),
  parameter int YW         = $clog2(MAX_HEIGHT + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output logic          cfg_wr,
  output logic [WW-1:0] width_eff,
  output logic [YW-1:0] height_eff
);

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(1024);
      image_height <= CFG_W'(1024);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[CFG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      default:          prdata = '0;
    endcase
  end

  // Zero counts as one, anything above the maximum is held at the maximum
  always_comb begin
    if (image_width == '0)
      width_eff = WW'(1);
    else if (32'(image_width) > 32'(MAX_WIDTH))
      width_eff = WW'(MAX_WIDTH);
    else
      width_eff = WW'(image_width);

    if (image_height == '0)
      height_eff = YW'(1);
    else if (32'(image_height) > 32'(MAX_HEIGHT))
      height_eff = YW'(MAX_HEIGHT);
    else
      height_eff = YW'(image_height);
  end

endmodule

[sv/crrd_line_buf.sv]
// Line buffers: last row's fill/foreign bits and the row before's fill bits.
module crrd_line_buf #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic [AW-1:0] rd_addr_right,
  input  logic          prev_we,
  input  logic [AW-1:0] prev_waddr,
  input  logic [1:0]    prev_wdata,
  input  logic          fill_we,
  input  logic [AW-1:0] fill_waddr,
  input  logic          fill_wdata,
  output logic [1:0]    center_q,
  output logic [1:0]    right_q,
  output logic          older_q
);

  logic [1:0] prev_mem [DEPTH];
  logic       fill_mem [DEPTH];

  // Read data holds until the next read, so a stalled stage keeps its operands
  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (rd_en) begin
      center_q <= prev_mem[rd_addr];
      right_q  <= prev_mem[rd_addr_right];
    end
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    if (rd_en) begin
      older_q <= fill_mem[rd_addr];
    end
  end

endmodule

[sv/crrd_resolve.sv]
// Resolve stage: combine neighbour bits into the painted result and register it.
module crrd_resolve import crrd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  tag_t       tag_in,
  input  logic       fwd_hit_in,
  input  logic       fwd_val_in,
  input  logic [1:0] center_q,
  input  logic [1:0] right_q,
  input  logic       older_q,
  input  logic       out_stall,
  output logic       busy,
  output logic       advance,
  output fill_wb_t   fill_wb,
  output logic       out_valid,
  output result_t    out_data
);

  tag_t    tag;
  logic    fwd_hit;
  logic    fwd_val;
  logic    last_fill;
  logic    c_fill;
  logic    c_foreign;
  logic    up;
  logic    left;
  logic    right;
  logic    ring;
  result_t res_next;

  assign c_fill    = center_q[0];
  assign c_foreign = center_q[1];
  // Take the bit being written this cycle when the store read raced it
  assign up        = tag.up_ok && (fwd_hit ? fwd_val : older_q);
  assign left      = tag.left_ok && last_fill;
  assign right     = tag.right_ok && right_q[0];
  assign ring      = !c_fill && !c_foreign && (up || left || right || tag.down);

  assign advance      = busy && (!out_valid || !out_stall);
  assign fill_wb.en   = advance && tag.emit;
  assign fill_wb.data = c_fill;

  always_comb begin
    res_next.texel_x    = tag.texel_x;
    res_next.texel_y    = tag.texel_y;
    res_next.painted    = c_fill || ring;
    res_next.from_ring  = ring;
    res_next.frame_last = tag.frame_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load)
        busy <= 1'b1;
      else if (advance)
        busy <= 1'b0;

      if (advance && tag.emit)
        out_valid <= 1'b1;
      else if (!out_stall)
        out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tag     <= tag_in;
      fwd_hit <= fwd_hit_in;
      fwd_val <= fwd_val_in;
    end
    if (advance && tag.emit) begin
      out_data  <= res_next;
      last_fill <= c_fill;
    end
  end

endmodule

[sv/claim_resolve_ring_dilation.sv]
// Single-ring 4-connected masked dilation over a raster stream of claim bits.
// Claims enter on claim/claim_valid/claim_stall, one texel per transfer in
// raster order; results leave on result/result_valid/result_stall. A transfer
// completes at a rising edge with valid high and stall low.
// Results lag one row: the texel at (x, y) releases the result for (x, y-1),
// so the first row gives no results, and after image_height rows a flush row
// of image_width texels (fields ignored) drains the last row; the counters
// then wrap and a new image begins. frame_last marks the image's final texel.
// A releasing transfer is read from the line buffers and held in the resolve
// stage; the output register raises result_valid. Throughput is one texel
// per cycle unless stalled, set by a single read/write pass per line buffer.
// A result waits in the output register while result_stall is high; one more
// texel is taken and held in the resolve stage, then claim_stall rises.
// Configuration lies on an APB-style port: image_width at 0, image_height at
// 4. A write restarts the frame. Reset restores both to 1024 and clears the
// counters; line buffers are not cleared, but unwritten words reach no result.
module claim_resolve_ring_dilation import crrd_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        claim_valid,
  output logic        claim_stall,
  input  claim_t      claim,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT + 1);

  logic          cfg_wr;
  logic [WW-1:0] width_eff;
  logic [YW-1:0] height_eff;

  logic [XW-1:0] col;
  logic [YW-1:0] row;
  logic [XW-1:0] col_next;
  logic [YW-1:0] row_next;
  logic [XW-1:0] b_col;
  logic [XW-1:0] addr_right;
  logic [WW-1:0] col_inc;
  logic          accept;
  logic          in_image;
  logic          filled;
  tag_t          tag_in;
  logic          fwd_hit_in;
  logic          busy;
  logic          advance;
  fill_wb_t      fill_wb;
  logic [1:0]    center_q;
  logic [1:0]    right_q;
  logic          older_q;

  crrd_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .WW        (WW),
    .YW        (YW)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_wr    (cfg_wr),
    .width_eff (width_eff),
    .height_eff(height_eff)
  );

  assign claim_stall = busy && !advance;
  assign accept      = claim_valid && !claim_stall;

  assign in_image = row < height_eff;
  assign filled   = claim.fill_inclusive && !(claim.foreign_inclusive && !claim.fill_strict);
  assign col_inc  = WW'(col) + WW'(1);

  assign addr_right = (col == XW'(MAX_WIDTH - 1)) ? '0 : col + XW'(1);

  always_comb begin
    tag_in.texel_x    = COORD_W'(col);
    tag_in.texel_y    = COORD_W'(row - YW'(1));
    tag_in.emit       = row != '0;
    tag_in.up_ok      = row >= YW'(2);
    tag_in.left_ok    = col != '0;
    tag_in.right_ok   = col_inc < width_eff;
    tag_in.down       = in_image && filled;
    tag_in.frame_last = (row == height_eff) && (col_inc == width_eff);
  end

  // The resolve stage writes the older-row store at the edge this read happens
  assign fwd_hit_in = fill_wb.en && (b_col == col);

  always_comb begin
    col_next = col + XW'(1);
    row_next = row;
    if (col_inc >= width_eff) begin
      col_next = '0;
      row_next = (row >= height_eff) ? '0 : row + YW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cfg_wr) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_col <= col;
    end
  end

  crrd_line_buf #(
    .DEPTH(MAX_WIDTH),
    .AW   (XW)
  ) u_line_buf (
    .clk          (clk),
    .rd_en        (accept),
    .rd_addr      (col),
    .rd_addr_right(addr_right),
    .prev_we      (accept && in_image),
    .prev_waddr   (col),
    .prev_wdata   ({claim.foreign_inclusive, filled}),
    .fill_we      (fill_wb.en),
    .fill_waddr   (b_col),
    .fill_wdata   (fill_wb.data),
    .center_q     (center_q),
    .right_q      (right_q),
    .older_q      (older_q)
  );

  crrd_resolve u_resolve (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .tag_in    (tag_in),
    .fwd_hit_in(fwd_hit_in),
    .fwd_val_in(fill_wb.data),
    .center_q  (center_q),
    .right_q   (right_q),
    .older_q   (older_q),
    .out_stall (result_stall),
    .busy      (busy),
    .advance   (advance),
    .fill_wb   (fill_wb),
    .out_valid (result_valid),
    .out_data  (result)
  );

`ifndef NO_ASSERTIONS
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    WW'(col) < width_eff)
    else $error("column counter beyond image width");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row <= height_eff)
    else $error("row counter beyond flush row");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    busy && !advance |=> busy)
    else $error("resolve stage dropped a held texel");

  a_ring_painted: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.from_ring |-> result.painted)
    else $error("ring texel reported as unpainted");
`endif

endmodule

[tb/tb_claim_resolve_ring_dilation.sv]
`timescale 1ns / 1ps
// Self-checking bench for ring dilation: directed and random claim images against a line-buffer model.
module tb_claim_resolve_ring_dilation import crrd_pkg::*;;

  localparam int MAX_W        = 1024;
  localparam int MAX_H        = 1024;
  localparam int SETTLE       = 8;
  localparam int RANDOM_ITEMS = 1750;
  localparam int DRAIN_GUARD  = 20000;
  localparam int SHORT_FRAME  = 400;

  logic        clk;
  logic        rst;
  logic        claim_valid;
  logic        claim_stall;
  claim_t      claim;
  logic        result_valid;
  logic        result_stall;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  claim_resolve_ring_dilation dut (
    .clk          (clk),
    .rst          (rst),
    .claim_valid  (claim_valid),
    .claim_stall  (claim_stall),
    .claim        (claim),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Line-buffer model state
  logic [1:0]  last_row_cls [MAX_W];
  logic        older_fill   [MAX_W];
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned img_w;
  int unsigned img_h;

  claim_t      pending_claims[$];
  result_t     expected_texels[$];
  result_t     want_texel;
  int unsigned claims_queued;
  int unsigned claims_taken;
  int unsigned mismatch_count;
  logic        calm;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned clamp_dim(input logic [31:0] value, input int unsigned maxv);
    int unsigned d;
    d = 32'(value[CFG_W-1:0]);
    if (d == 0) d = 1;
    if (d > maxv) d = maxv;
    return d;
  endfunction

  function automatic logic [31:0] dim_word(input int unsigned v);
    logic [31:0] w;
    w = 32'(v);
    // Upper bits are outside the register; scatter junk there now and then
    if ($urandom_range(2) == 0) w = ($urandom() & 32'hFFFF_F800) | (w & 32'h0000_07FF);
    return w;
  endfunction

  function automatic claim_t random_claim(input int unsigned density);
    claim_t c;
    c.fill_inclusive    = ($urandom_range(99) < density);
    c.fill_strict       = 1'($urandom_range(1));
    c.foreign_inclusive = ($urandom_range(99) < 30);
    return c;
  endfunction

  task automatic apply_dim(input reg_index_t idx, input logic [31:0] value);
    if (idx == REG_IMAGE_WIDTH) img_w = clamp_dim(value, MAX_W);
    else img_h = clamp_dim(value, MAX_H);
    col_pos = 0;
    row_pos = 0;
  endtask

  task automatic resolve_claim(input claim_t c);
    int unsigned x;
    int unsigned y;
    logic [1:0]  cur;
    logic [1:0]  center;
    logic        up;
    logic        down;
    logic        left;
    logic        right;
    logic        ring;
    result_t     r;
    x = col_pos;
    y = row_pos;
    if (x >= img_w) x = img_w - 1;
    if (y > img_h) y = img_h;
    cur = 2'b00;
    // Flush row carries no claims
    if (y < img_h) begin
      cur[0] = c.fill_inclusive && !(c.foreign_inclusive && !c.fill_strict);
      cur[1] = c.foreign_inclusive;
    end
    if (y > 0) begin
      center = last_row_cls[x];
      up     = (y >= 2) ? older_fill[x] : 1'b0;
      down   = cur[0];
      left   = (x > 0) ? older_fill[x-1] : 1'b0;
      right  = (x + 1 < img_w) ? last_row_cls[x+1][0] : 1'b0;
      ring   = !center[0] && !center[1] && (up || down || left || right);
      r.texel_x    = COORD_W'(x);
      r.texel_y    = COORD_W'(y - 1);
      r.painted    = center[0] || ring;
      r.from_ring  = ring;
      r.frame_last = (y == img_h) && (x == img_w - 1);
      expected_texels.push_back(r);
      older_fill[x] = center[0];
    end
    if (y < img_h) last_row_cls[x] = cur;
    x++;
    if (x >= img_w) begin
      x = 0;
      y++;
      if (y > img_h) y = 0;
    end
    col_pos = x;
    row_pos = y;
  endtask

  task automatic queue_claim(input claim_t c);
    pending_claims.push_back(c);
    claims_queued++;
  endtask

  task automatic write_dim(input reg_index_t idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apply_dim(idx, value);
  endtask

  task automatic wait_transfers_done();
    while (claims_taken != claims_queued) @(posedge clk);
  endtask

  // Block goes quiet: every claim taken, every result back, pipeline settled
  task automatic wait_frame_idle();
    int guard;
    guard = 0;
    wait_transfers_done();
    while (expected_texels.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    if (expected_texels.size() != 0) begin
      if (mismatch_count < 10)
        $display("missing results: %0d still expected", expected_texels.size());
      mismatch_count++;
      expected_texels.delete();
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // Claim driver
  always @(posedge clk) begin
    if (rst) begin
      claim_valid <= 1'b0;
    end else begin
      if (claim_valid && !claim_stall) begin
        resolve_claim(claim);
        claims_taken++;
      end
      if (!claim_valid || !claim_stall) begin
        if (pending_claims.size() != 0 && (calm || $urandom_range(99) >= 13)) begin
          claim       <= pending_claims.pop_front();
          claim_valid <= 1'b1;
        end else begin
          claim_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_texels.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result: x=%0d y=%0d painted=%b ring=%b last=%b",
                     result.texel_x, result.texel_y, result.painted,
                     result.from_ring, result.frame_last);
          mismatch_count++;
        end else begin
          want_texel = expected_texels.pop_front();
          if (result.texel_x !== want_texel.texel_x || result.texel_y !== want_texel.texel_y ||
              result.painted !== want_texel.painted ||
              result.from_ring !== want_texel.from_ring ||
              result.frame_last !== want_texel.frame_last) begin
            if (mismatch_count < 10)
              $display("mismatch: expected x=%0d y=%0d p=%b r=%b l=%b, got x=%0d y=%0d p=%b r=%b l=%b",
                       want_texel.texel_x, want_texel.texel_y, want_texel.painted,
                       want_texel.from_ring, want_texel.frame_last,
                       result.texel_x, result.texel_y, result.painted,
                       result.from_ring, result.frame_last);
            mismatch_count++;
          end
        end
      end
      result_stall <= !calm && ($urandom_range(99) < 13);
    end
  end

  initial begin
    #2_000_000;
    $display("claim_resolve_ring_dilation test failed");
    $finish;
  end

  initial begin
    int unsigned w_next;
    int unsigned h_next;
    int unsigned frame_len;
    int unsigned n;
    int unsigned density;
    int unsigned random_done;
    int unsigned shape;
    int unsigned pick;
    logic        first_phase;
    logic        pressed;
    clk            = 1'b0;
    rst            = 1'b1;
    claim_valid    = 1'b0;
    claim          = '0;
    result_stall   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    calm           = 1'b0;
    claims_queued  = 0;
    claims_taken   = 0;
    mismatch_count = 0;
    for (int i = 0; i < MAX_W; i++) begin
      last_row_cls[i] = 2'b00;
      older_fill[i]   = 1'b0;
    end
    col_pos = 0;
    row_pos = 0;
    img_w   = MAX_W;
    img_h   = MAX_H;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // 3x2 image: strict overrides foreign, foreign blocks the ring, edges
    write_dim(REG_IMAGE_WIDTH, 32'd3);
    write_dim(REG_IMAGE_HEIGHT, 32'd2);
    queue_claim(claim_t'(3'b100));
    queue_claim(claim_t'(3'b000));
    queue_claim(claim_t'(3'b101));
    queue_claim(claim_t'(3'b111));
    queue_claim(claim_t'(3'b001));
    queue_claim(claim_t'(3'b000));
    // flush row: fields must be ignored
    queue_claim(claim_t'(3'b111));
    queue_claim(claim_t'(3'b111));
    queue_claim(claim_t'(3'b111));
    wait_frame_idle();

    // Zero in both registers means a 1x1 image; three frames back to back
    write_dim(REG_IMAGE_WIDTH, 32'd0);
    write_dim(REG_IMAGE_HEIGHT, 32'd0);
    queue_claim(claim_t'(3'b111));
    queue_claim(claim_t'(3'b000));
    queue_claim(claim_t'(3'b000));
    queue_claim(claim_t'(3'b111));
    queue_claim(claim_t'(3'b110));
    queue_claim(claim_t'(3'b001));
    wait_frame_idle();

    // Widest row, clamped from above; first half with no idling at all
    write_dim(REG_IMAGE_WIDTH, 32'd2047);
    write_dim(REG_IMAGE_HEIGHT, 32'hFFFF_F800);
    calm = 1'b1;
    for (int i = 0; i < MAX_W; i++) queue_claim(random_claim(50));
    wait_transfers_done();
    calm = 1'b0;
    for (int i = 0; i < MAX_W; i++) queue_claim(random_claim(50));
    wait_frame_idle();

    // Tallest column, clamped from above
    write_dim(REG_IMAGE_WIDTH, 32'd1);
    write_dim(REG_IMAGE_HEIGHT, 32'd2047);
    for (int i = 0; i < MAX_H + 1; i++) queue_claim(random_claim(40));
    wait_frame_idle();

    random_done = 0;
    first_phase = 1'b1;
    pressed     = 1'b0;
    while (random_done < RANDOM_ITEMS) begin
      shape = $urandom_range(9);
      if (shape == 0) begin
        w_next = $urandom_range(13, 80);
        h_next = $urandom_range(0, 2);
      end else if (shape == 1) begin
        w_next = $urandom_range(0, 3);
        h_next = $urandom_range(9, 40);
      end else begin
        w_next = $urandom_range(0, 12);
        h_next = $urandom_range(0, 8);
      end
      // 1: width only, 2: height only, else both
      pick = first_phase ? 0 : $urandom_range(3);
      if (pick == 1 && clamp_dim(w_next, MAX_W) * (img_h + 1) > SHORT_FRAME) pick = 0;
      if (pick == 2 && img_w * (clamp_dim(h_next, MAX_H) + 1) > SHORT_FRAME) pick = 0;
      if (pick == 3) begin
        write_dim(REG_IMAGE_HEIGHT, dim_word(h_next));
        write_dim(REG_IMAGE_WIDTH, dim_word(w_next));
      end else begin
        if (pick != 2) write_dim(REG_IMAGE_WIDTH, dim_word(w_next));
        if (pick != 1) write_dim(REG_IMAGE_HEIGHT, dim_word(h_next));
      end
      first_phase = 1'b0;
      frame_len = img_w * (img_h + 1);
      density   = $urandom_range(10, 90);
      n = frame_len * ((frame_len > 100) ? 1 : $urandom_range(1, 3));
      // Sometimes stop part-way through a frame so the next write restarts it
      if ($urandom_range(3) == 0) n += $urandom_range(1, frame_len);
      for (int i = 0; i < n; i++) begin
        if (!pressed && n >= 8 && i == n / 2) begin
          // Hold the sender mid-frame until every pending result is out
          wait_transfers_done();
          while (expected_texels.size() != 0) @(posedge clk);
          pressed = 1'b1;
        end
        queue_claim(random_claim(density));
      end
      random_done += n;
      wait_frame_idle();
    end

    repeat (4 * SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("claim_resolve_ring_dilation test passed");
    end else begin
      $display("claim_resolve_ring_dilation test failed");
    end
    $finish;
  end

endmodule

[claim_resolve_ring_dilation.f]
sv/crrd_pkg.sv
sv/crrd_cfg.sv
sv/crrd_line_buf.sv
sv/crrd_resolve.sv
sv/claim_resolve_ring_dilation.sv
tb/tb_claim_resolve_ring_dilation.sv
